FILE: rtl/bscee_pkg.sv
// shared types, constants and helpers for the button and stick event encoder
`default_nettype none

package bscee_pkg;

	// input item kinds
	localparam logic KIND_OPEN = 1'b0;
	localparam logic KIND_READ = 1'b1;

	// button table
	localparam int TBL_SIZE    = 9;
	localparam int NUM_BUTTONS = 9;
	localparam int BTN_LIMIT   = (NUM_BUTTONS < TBL_SIZE) ? NUM_BUTTONS : TBL_SIZE;
	localparam logic [TBL_SIZE-1:0] BTN_MASK =
		TBL_SIZE'((TBL_SIZE+1)'(1) << BTN_LIMIT) - TBL_SIZE'(1);

	// slot numbers in the event mask, buttons occupy the low slots
	localparam int NUM_SLOTS = 12;
	localparam logic [3:0] SLOT_X    = 4'd9;
	localparam logic [3:0] SLOT_Y    = 4'd10;
	localparam logic [3:0] SLOT_SYNC = 4'd11;

	// event types
	localparam logic [7:0] EV_SYN    = 8'h00;
	localparam logic [7:0] EV_KEY    = 8'h01;
	localparam logic [7:0] EV_ABS    = 8'h03;
	localparam logic [7:0] JS_BUTTON = 8'h01;
	localparam logic [7:0] JS_AXIS   = 8'h02;
	localparam logic [7:0] JS_INIT   = 8'h80;

	// axis codes
	localparam logic [1:0] AXIS_ZERO = 2'd0;
	localparam logic [1:0] AXIS_POS  = 2'd1;
	localparam logic [1:0] AXIS_NEG  = 2'd2;
	localparam logic signed [15:0] AXIS_FULL = 16'sd32767;

	// job queue depth, a power of two
	localparam int JOBQ_DEPTH = 4;

	// one classified read, handed from front to back
	typedef struct packed {
		logic                  empty;
		logic                  js;
		logic                  init;
		logic [TBL_SIZE-1:0]   btns;
		logic [1:0]            ax;
		logic [1:0]            ay;
		logic [NUM_SLOTS-1:0]  mask;
		logic [3:0]            room;
	} job_t;

	// event-device key code of a button
	function automatic logic [8:0] key_code(input logic [3:0] idx);
		logic [8:0] code;
		case (idx)
			4'd0: code = 9'h130;
			4'd1: code = 9'h131;
			4'd2: code = 9'h133;
			4'd3: code = 9'h134;
			4'd4: code = 9'h136;
			4'd5: code = 9'h137;
			4'd6: code = 9'h13a;
			4'd7: code = 9'h13b;
			4'd8: code = 9'h13d;
			default: code = 9'h000;
		endcase
		return code;
	endfunction

	// axis position of an axis code
	function automatic logic signed [15:0] axis_value(input logic [1:0] code);
		logic signed [15:0] v;
		case (code)
			AXIS_POS: v = AXIS_FULL;
			AXIS_NEG: v = -AXIS_FULL;
			default:  v = 16'sd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/bscee_front.sv
// front: accepts snapshots, keeps the baseline and classifies reads into jobs
`default_nettype none

module bscee_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_wr_en,
	input  wire logic                cfg_wr_data,
	input  wire logic                accept,
	input  wire logic                kind,
	input  wire logic [8:0]          face_buttons,
	input  wire logic [7:0]          directions,
	input  wire logic [3:0]          room,
	output bscee_pkg::job_t          job,
	output logic                     push
);

	logic                          node_mode_q;
	logic                          opened_q;
	logic                          init_sent_q;
	logic [bscee_pkg::TBL_SIZE-1:0] prev_btns_q;
	logic [1:0]                    prev_ax_q;
	logic [1:0]                    prev_ay_q;

	logic       up, dn, lf, rt;
	logic [1:0] ax, ay;
	logic [bscee_pkg::TBL_SIZE-1:0] chg;
	logic       x_chg, y_chg, any_chg;
	logic       do_init;

	// fold directions into axis codes
	always_comb begin
		up = directions[0] | directions[4] | directions[5];
		dn = directions[1] | directions[6] | directions[7];
		lf = directions[2] | directions[4] | directions[6];
		rt = directions[3] | directions[5] | directions[7];
		ax = rt ? bscee_pkg::AXIS_POS : (lf ? bscee_pkg::AXIS_NEG : bscee_pkg::AXIS_ZERO);
		ay = dn ? bscee_pkg::AXIS_POS : (up ? bscee_pkg::AXIS_NEG : bscee_pkg::AXIS_ZERO);
	end

	// classify the read
	always_comb begin
		chg     = (face_buttons ^ prev_btns_q) & bscee_pkg::BTN_MASK;
		x_chg   = (ax != prev_ax_q);
		y_chg   = (ay != prev_ay_q);
		any_chg = (|chg) | x_chg | y_chg;
		do_init = node_mode_q & ~init_sent_q;

		job.js   = node_mode_q;
		job.btns = face_buttons;
		job.ax   = ax;
		job.ay   = ay;
		job.room = room;
		job.init = do_init;
		if (do_init) begin
			job.mask = {1'b0, 1'b1, 1'b1, bscee_pkg::BTN_MASK};
		end else begin
			job.mask = {~node_mode_q & any_chg, y_chg, x_chg, chg};
		end
		job.empty = ~opened_q | (job.mask == '0) | (room == 4'd0);
		push = accept & (kind == bscee_pkg::KIND_READ);
	end

	// configuration register and baseline state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_mode_q <= 1'b0;
			opened_q    <= 1'b0;
			init_sent_q <= 1'b0;
			prev_btns_q <= '0;
			prev_ax_q   <= bscee_pkg::AXIS_ZERO;
			prev_ay_q   <= bscee_pkg::AXIS_ZERO;
		end else begin
			if (cfg_wr_en) begin
				node_mode_q <= cfg_wr_data;
			end
			if (accept) begin
				if (kind == bscee_pkg::KIND_OPEN) begin
					opened_q    <= 1'b1;
					init_sent_q <= 1'b0;
					prev_btns_q <= face_buttons;
					prev_ax_q   <= ax;
					prev_ay_q   <= ay;
				end else if (opened_q) begin
					if (do_init) begin
						init_sent_q <= 1'b1;
					end
					prev_btns_q <= face_buttons;
					prev_ax_q   <= ax;
					prev_ay_q   <= ay;
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/bscee_fifo.sv
// short job queue between front and back
`default_nettype none

module bscee_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire bscee_pkg::job_t push_job,
	output logic                 full,
	input  wire logic            pop,
	output bscee_pkg::job_t      head_job,
	output logic                 empty
);

	localparam int PW = $clog2(bscee_pkg::JOBQ_DEPTH);
	localparam int CW = $clog2(bscee_pkg::JOBQ_DEPTH + 1);

	bscee_pkg::job_t slots_q [bscee_pkg::JOBQ_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full     = (count_q == CW'(bscee_pkg::JOBQ_DEPTH));
	assign empty    = (count_q == '0);
	assign head_job = slots_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("job pushed into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop) else $error("job popped from empty queue");
`endif

endmodule

`default_nettype wire

FILE: rtl/bscee_back.sv
// back: walks a job's event mask and drives the output register
`default_nettype none

module bscee_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire bscee_pkg::job_t head_job,
	input  wire logic            q_empty,
	output logic                 pop,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output logic [39:0]          m_tdata,
	output logic                 m_tlast,
	output logic                 m_tuser
);

	bscee_pkg::job_t                 job_q;
	logic                            busy_q;
	logic [bscee_pkg::NUM_SLOTS-1:0] rem_mask_q;
	logic [3:0]                      rem_room_q;
	logic                            m_tvalid_q;
	logic [39:0]                     m_tdata_q;
	logic                            m_tlast_q;
	logic                            m_tuser_q;

	logic                            adv;
	logic [3:0]                      sel;
	logic [bscee_pkg::NUM_SLOTS-1:0] low_bit;
	logic [bscee_pkg::NUM_SLOTS-1:0] mask_nxt;
	logic                            last;
	logic [7:0]                      ev_type;
	logic [8:0]                      ev_code;
	logic signed [15:0]              ev_value;

	assign adv = ~m_tvalid_q | m_tready;
	assign pop = ~busy_q & ~q_empty;

	// pick the lowest pending slot
	always_comb begin
		sel = '0;
		for (int i = bscee_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
			if (rem_mask_q[i]) begin
				sel = 4'(i);
			end
		end
		low_bit  = rem_mask_q & (~rem_mask_q + bscee_pkg::NUM_SLOTS'(1));
		mask_nxt = rem_mask_q & ~low_bit;
		last     = job_q.empty | (mask_nxt == '0) | (rem_room_q == 4'd1);
	end

	// encode the selected event
	always_comb begin
		ev_type  = bscee_pkg::EV_SYN;
		ev_code  = '0;
		ev_value = 16'sd0;
		if (!job_q.empty) begin
			case (sel)
				bscee_pkg::SLOT_X: begin
					ev_type  = job_q.init ? (bscee_pkg::JS_INIT | bscee_pkg::JS_AXIS)
						: (job_q.js ? bscee_pkg::JS_AXIS : bscee_pkg::EV_ABS);
					ev_code  = 9'd0;
					ev_value = bscee_pkg::axis_value(job_q.ax);
				end
				bscee_pkg::SLOT_Y: begin
					ev_type  = job_q.init ? (bscee_pkg::JS_INIT | bscee_pkg::JS_AXIS)
						: (job_q.js ? bscee_pkg::JS_AXIS : bscee_pkg::EV_ABS);
					ev_code  = 9'd1;
					ev_value = bscee_pkg::axis_value(job_q.ay);
				end
				bscee_pkg::SLOT_SYNC: begin
					ev_type  = bscee_pkg::EV_SYN;
					ev_code  = 9'd0;
					ev_value = 16'sd0;
				end
				default: begin
					ev_type  = job_q.init ? (bscee_pkg::JS_INIT | bscee_pkg::JS_BUTTON)
						: (job_q.js ? bscee_pkg::JS_BUTTON : bscee_pkg::EV_KEY);
					ev_code  = (job_q.init || job_q.js) ? {5'd0, sel}
						: bscee_pkg::key_code(sel);
					ev_value = {15'd0, job_q.btns[sel]};
				end
			endcase
		end
	end

	// job sequencing and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
			end else if (busy_q && adv && last) begin
				busy_q <= 1'b0;
			end
			if (adv) begin
				m_tvalid_q <= busy_q;
			end
		end
	end

	// job payload and output payload
	always_ff @(posedge clk) begin
		if (pop) begin
			job_q      <= head_job;
			rem_mask_q <= head_job.mask;
			rem_room_q <= head_job.room;
		end else if (busy_q && adv) begin
			rem_mask_q <= mask_nxt;
			rem_room_q <= rem_room_q - 4'd1;
		end
		if (busy_q && adv) begin
			m_tdata_q <= {7'd0, ev_value, ev_code, ev_type};
			m_tlast_q <= ~job_q.empty & last;
			m_tuser_q <= job_q.empty;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

`ifndef NO_ASSERTIONS
	a_live_job: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !job_q.empty) |-> (rem_room_q != 4'd0 && rem_mask_q != '0))
		else $error("active job has no room or no pending slot");
	a_empty_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (!m_tlast && m_tdata == '0))
		else $error("empty result carries data");
`endif

endmodule

`default_nettype wire

FILE: rtl/button_stick_change_event_encoder.sv
// top level of the button and stick change-event encoder
//
// Usage:
//  s_* channel takes one snapshot per transaction: s_tuser is the kind
//  (0 open, 1 read), s_tdata holds the buttons, directions and reader room.
//  An open transaction records the baseline and produces nothing. A read
//  produces one to twelve events on m_*, m_tlast marking the final one,
//  or a single empty result with m_tuser high and zero data.
//  cfg_wr_en/cfg_wr_data write node_mode (0 event-device, 1 joystick); write
//  it only while no read is in flight.
//  The back end emits one event per cycle unless m_tready stalls it, and
//  loads a new job only after finishing the current one; that event walk
//  sets the throughput. Up to four classified reads wait in the job queue,
//  so s_tready stays high while the back end catches up. Reset clears the
//  baseline, the opened and initial-state flags, node_mode and the queue.
//  When the receiver stalls, the output register holds its event, the back
//  end waits, and once the queue fills s_tready drops.
`default_nettype none

module button_stick_change_event_encoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic        cfg_wr_data,   // node_mode
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,       // face_buttons[8:0], directions[16:9], room[20:17]
	input  wire logic        s_tuser,       // kind
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,       // event_type[7:0], event_code[16:8], event_value[32:17]
	output logic             m_tlast,       // last_of_run
	output logic             m_tuser        // empty_res
);

	bscee_pkg::job_t push_job;
	bscee_pkg::job_t head_job;
	logic            push;
	logic            pop;
	logic            q_full;
	logic            q_empty;
	logic            accept;

	assign s_tready = ~q_full;
	assign accept   = s_tvalid & s_tready;

	// classification front end
	bscee_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.accept       (accept),
		.kind         (s_tuser),
		.face_buttons (s_tdata[8:0]),
		.directions   (s_tdata[16:9]),
		.room         (s_tdata[20:17]),
		.job          (push_job),
		.push         (push)
	);

	// job queue
	bscee_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.head_job (head_job),
		.empty    (q_empty)
	);

	// event generation back end
	bscee_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_job (head_job),
		.q_empty  (q_empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire
